[hw/rtl/butterworth_lowpass_biquad_cascade_top_assert.svh]
// Assertion macros for the biquad cascade RTL.
`ifndef BUTTERWORTH_LOWPASS_BIQUAD_CASCADE_TOP_ASSERT_SVH
`define BUTTERWORTH_LOWPASS_BIQUAD_CASCADE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BWLP_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bwlp assertion failed");

`define BWLP_ASSERT(label, prop) `BWLP_ASSERT_CLK(label, aclk, aresetn, prop)

`else

`define BWLP_ASSERT_CLK(label, clk, rst_n, prop)

`define BWLP_ASSERT(label, prop)

`endif

`endif

[hw/rtl/bwlp_pkg.sv]
`timescale 1ns / 1ps

package bwlp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int ACC_W      = SAMPLE_W + 32;
    localparam int IFRAC      = 29;
    localparam int CFRAC      = COEF_W - 3;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = COEF_W / DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int PROD_W     = ACC_W + DIGIT_W + 1;
    localparam int LOW_BITS   = DIGIT_W * (NUM_DIGITS - 1);
    localparam int RSH        = CFRAC - LOW_BITS;
    localparam int SUM_W      = PROD_W - RSH;
    localparam int Q_W        = ACC_W - IFRAC + 1;
    localparam int NUM_REGS   = 6;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_B0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_A1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_A2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_B0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_A1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_A2 = 3'd5;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef struct packed {
        coef_t b0;
        coef_t a1;
        coef_t a2;
    } sec_coef_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    function automatic sum_t ext_acc(input acc_t v);
        return {{(SUM_W - ACC_W){v[ACC_W-1]}}, v};
    endfunction

    function automatic acc_t sat_acc(input sum_t v);
        logic fits;
        acc_t lim;
        fits = (&v[SUM_W-1:ACC_W-1]) | ~(|v[SUM_W-1:ACC_W-1]);
        lim  = v[SUM_W-1] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        return fits ? v[ACC_W-1:0] : lim;
    endfunction

endpackage

[hw/rtl/bwlp_coef_regs.sv]
`timescale 1ns / 1ps

module bwlp_coef_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bwlp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bwlp_pkg::COEF_W-1:0]         cfg_data,
    output bwlp_pkg::sec_coef_t [1:0]           coef
);

    bwlp_pkg::sec_coef_t [1:0] coef_reg;
    bwlp_pkg::sec_coef_t [1:0] coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb begin
        coef_next = coef_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                bwlp_pkg::REG_FIRST_B0:  coef_next[0].b0 = cfg_data;
                bwlp_pkg::REG_FIRST_A1:  coef_next[0].a1 = cfg_data;
                bwlp_pkg::REG_FIRST_A2:  coef_next[0].a2 = cfg_data;
                bwlp_pkg::REG_SECOND_B0: coef_next[1].b0 = cfg_data;
                bwlp_pkg::REG_SECOND_A1: coef_next[1].a1 = cfg_data;
                bwlp_pkg::REG_SECOND_A2: coef_next[1].a2 = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

endmodule

[hw/rtl/bwlp_serial_mul.sv]
`timescale 1ns / 1ps

`include "butterworth_lowpass_biquad_cascade_top_assert.svh"

module bwlp_serial_mul (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  bwlp_pkg::coef_t      coef,
    input  bwlp_pkg::acc_t       opnd,
    output bwlp_pkg::mul_stat_t  stat,
    output bwlp_pkg::acc_t       result
);

    localparam logic [bwlp_pkg::CNT_W-1:0] LAST_DIGIT = bwlp_pkg::CNT_W'(bwlp_pkg::NUM_DIGITS - 1);

    logic                               busy_reg, busy_next;
    logic                               round_reg, round_next;
    logic                               done_reg, done_next;
    logic [bwlp_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [bwlp_pkg::COEF_W-1:0]        coef_sh_reg, coef_sh_next;
    bwlp_pkg::acc_t                     opnd_reg, opnd_next;
    logic signed [bwlp_pkg::PROD_W-1:0] acc_reg, acc_next;
    bwlp_pkg::acc_t                     result_reg, result_next;

    logic                               last_digit;
    logic [bwlp_pkg::DIGIT_W-1:0]       digit;
    logic signed [bwlp_pkg::DIGIT_W:0]  digit_s;
    logic signed [bwlp_pkg::PROD_W-1:0] pp;
    logic signed [bwlp_pkg::PROD_W-1:0] sum;
    bwlp_pkg::sum_t                     rounded;

    assign last_digit = (cnt_reg == LAST_DIGIT);
    assign digit      = coef_sh_reg[bwlp_pkg::DIGIT_W-1:0];
    assign digit_s    = last_digit ? {digit[bwlp_pkg::DIGIT_W-1], digit} : {1'b0, digit};
    assign pp         = opnd_reg * digit_s;
    assign sum        = acc_reg + pp;
    assign rounded    = acc_reg[bwlp_pkg::PROD_W-1:bwlp_pkg::RSH]
                      + bwlp_pkg::SUM_W'(acc_reg[bwlp_pkg::RSH-1]);

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = result_reg;

    always_comb begin
        busy_next    = busy_reg;
        round_next   = round_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        coef_sh_next = coef_sh_reg;
        opnd_next    = opnd_reg;
        acc_next     = acc_reg;
        result_next  = result_reg;
        if (start) begin
            busy_next    = 1'b1;
            round_next   = 1'b0;
            cnt_next     = '0;
            coef_sh_next = coef;
            opnd_next    = opnd;
            acc_next     = '0;
        end else if (busy_reg && round_reg) begin
            // drop the fraction with round half up, then clamp to the accumulator width
            result_next = bwlp_pkg::sat_acc(rounded);
            done_next   = 1'b1;
            busy_next   = 1'b0;
            round_next  = 1'b0;
        end else if (busy_reg) begin
            if (last_digit) begin
                acc_next   = sum;
                round_next = 1'b1;
            end else begin
                acc_next     = sum >>> bwlp_pkg::DIGIT_W;
                coef_sh_next = coef_sh_reg >> bwlp_pkg::DIGIT_W;
                cnt_next     = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        coef_sh_reg <= coef_sh_next;
        opnd_reg    <= opnd_next;
        acc_reg     <= acc_next;
        result_reg  <= result_next;
    end

    `BWLP_ASSERT(a_start_when_idle, start |-> !busy_reg)
    `BWLP_ASSERT(a_done_after_round, done_reg |-> $past(round_reg))
    `BWLP_ASSERT(a_last_digit_rounds,
        (busy_reg && !round_reg && !start && last_digit) |=> (round_reg && busy_reg))

endmodule

[hw/rtl/butterworth_lowpass_biquad_cascade_top.sv]
`timescale 1ns / 1ps

`include "butterworth_lowpass_biquad_cascade_top_assert.svh"

// Fourth-order low-pass IIR: two transposed direct-form II biquads in series.
// Input stream s_*: one signed 16-bit sample per transaction.
// Output stream m_*: one filtered sample per input, rounded and saturated to
// 16 bits, with a clip flag in m_tuser.
// Config channel cfg_*: write coefficient register cfg_index (0..5 =
// first b0, a1, a2, second b0, a1, a2; Q3.29); indexes 6 and 7 are ignored.
// cfg_ready is always high. Write coefficients only while the filter is idle.
// All six products run through one shared digit-serial multiplier that takes
// 8 coefficient bits per cycle: four digit steps, then a rounding step and a
// hand-off step per product. A new sample is taken only in the idle state,
// after the previous one has passed all six products and reached the output
// register.
// The output register frees the input side: the next sample is accepted while
// a result still waits. If the receiver stalls longer, the next result is held
// until m_tready rises, and input is held off in the meantime.
// Reset (aresetn low, synchronous) clears the coefficients, the four delay
// registers and the output valid.
module butterworth_lowpass_biquad_cascade_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // [15:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [15:0] filtered
    output logic [0:0]                        m_tuser,   // [0] clipped
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bwlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bwlp_pkg::COEF_W-1:0]       cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MB0  = 3'd1;
    localparam logic [2:0] ST_MA1  = 3'd2;
    localparam logic [2:0] ST_MA2  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int PAD_W = bwlp_pkg::ACC_W - bwlp_pkg::SAMPLE_W - bwlp_pkg::IFRAC;

    bwlp_pkg::sec_coef_t [1:0] coef;
    bwlp_pkg::mul_stat_t       mul_stat;
    bwlp_pkg::acc_t            mul_result;
    logic                      mul_start;
    bwlp_pkg::coef_t           mul_coef;
    bwlp_pkg::acc_t            mul_opnd;

    logic [2:0]                state_reg, state_next;
    logic                      sec_reg, sec_next;
    bwlp_pkg::acc_t            bx_reg, bx_next;
    bwlp_pkg::acc_t            y_reg, y_next;
    bwlp_pkg::acc_t            m1_reg, m1_next;
    bwlp_pkg::acc_t            d1_reg [2];
    bwlp_pkg::acc_t            d1_next [2];
    bwlp_pkg::acc_t            d2_reg [2];
    bwlp_pkg::acc_t            d2_next [2];
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [15:0]               m_tdata_reg, m_tdata_next;
    logic                      m_tuser_reg, m_tuser_next;

    bwlp_pkg::acc_t            x_in;
    logic signed [bwlp_pkg::Q_W-1:0] q;
    logic                      q_fits;
    logic                      s_accept;

    bwlp_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    bwlp_serial_mul u_serial_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .coef    (mul_coef),
        .opnd    (mul_opnd),
        .stat    (mul_stat),
        .result  (mul_result)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign x_in   = {{PAD_W{s_tdata[15]}}, s_tdata, {bwlp_pkg::IFRAC{1'b0}}};
    assign q      = {y_reg[bwlp_pkg::ACC_W-1], y_reg[bwlp_pkg::ACC_W-1:bwlp_pkg::IFRAC]}
                  + bwlp_pkg::Q_W'(y_reg[bwlp_pkg::IFRAC-1]);
    assign q_fits = (&q[bwlp_pkg::Q_W-1:bwlp_pkg::SAMPLE_W-1])
                  | ~(|q[bwlp_pkg::Q_W-1:bwlp_pkg::SAMPLE_W-1]);

    always_comb begin
        state_next    = state_reg;
        sec_next      = sec_reg;
        bx_next       = bx_reg;
        y_next        = y_reg;
        m1_next       = m1_reg;
        d1_next       = d1_reg;
        d2_next       = d2_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mul_start     = 1'b0;
        mul_coef      = coef[0].b0;
        mul_opnd      = x_in;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    mul_start  = 1'b1;
                    sec_next   = 1'b0;
                    state_next = ST_MB0;
                end
            end
            ST_MB0: begin
                if (mul_stat.done) begin
                    bx_next    = mul_result;
                    y_next     = bwlp_pkg::sat_acc(bwlp_pkg::ext_acc(mul_result)
                                                 + bwlp_pkg::ext_acc(d1_reg[sec_reg]));
                    mul_start  = 1'b1;
                    mul_coef   = coef[sec_reg].a1;
                    mul_opnd   = y_next;
                    state_next = ST_MA1;
                end
            end
            ST_MA1: begin
                if (mul_stat.done) begin
                    m1_next    = mul_result;
                    mul_start  = 1'b1;
                    mul_coef   = coef[sec_reg].a2;
                    mul_opnd   = y_reg;
                    state_next = ST_MA2;
                end
            end
            ST_MA2: begin
                if (mul_stat.done) begin
                    d1_next[sec_reg] = bwlp_pkg::sat_acc((bwlp_pkg::ext_acc(bx_reg) <<< 1)
                                                       - bwlp_pkg::ext_acc(m1_reg)
                                                       + bwlp_pkg::ext_acc(d2_reg[sec_reg]));
                    d2_next[sec_reg] = bwlp_pkg::sat_acc(bwlp_pkg::ext_acc(bx_reg)
                                                       - bwlp_pkg::ext_acc(mul_result));
                    if (!sec_reg) begin
                        // advance to section two with its input in hand
                        mul_start  = 1'b1;
                        mul_coef   = coef[1].b0;
                        mul_opnd   = y_reg;
                        sec_next   = 1'b1;
                        state_next = ST_MB0;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = !q_fits;
                    if (q_fits) begin
                        m_tdata_next = q[15:0];
                    end else begin
                        m_tdata_next = q[bwlp_pkg::Q_W-1] ? 16'h8000 : 16'h7fff;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sec_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            d1_reg       <= '{default: '0};
            d2_reg       <= '{default: '0};
        end else begin
            state_reg    <= state_next;
            sec_reg      <= sec_next;
            m_tvalid_reg <= m_tvalid_next;
            d1_reg       <= d1_next;
            d2_reg       <= d2_next;
        end
    end

    always_ff @(posedge aclk) begin
        bx_reg      <= bx_next;
        y_reg       <= y_next;
        m1_reg      <= m1_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    `BWLP_ASSERT(a_accept_starts_mul,
        s_accept |=> (state_reg == ST_MB0 && !sec_reg && mul_stat.busy))
    `BWLP_ASSERT(a_done_in_wait_state,
        mul_stat.done |-> (state_reg == ST_MB0 || state_reg == ST_MA1 || state_reg == ST_MA2))
    `BWLP_ASSERT(a_out_waits_on_stall,
        (state_reg == ST_OUT && m_tvalid_reg && !m_tready) |=> (state_reg == ST_OUT))

endmodule
